### rtl/sbf_pkg.sv
// Shared types, constants and field tables for the binary block deframer.
// No dependencies; every other file of the block imports this package.
package sbf_pkg;

	// Block size limits and payload store layout
	localparam int MAX_BLOCK_BYTES = 200;
	localparam int HDR_BYTES       = 8;
	localparam int STORE_DEPTH     = MAX_BLOCK_BYTES - HDR_BYTES;
	localparam int PLEN_W          = $clog2(STORE_DEPTH + 1);
	localparam int FIELD_WORDS     = 9;
	localparam int STORE_WORDS     = (STORE_DEPTH + 7) / 8;
	localparam int BANK_WORDS      = (STORE_WORDS > FIELD_WORDS) ? STORE_WORDS : FIELD_WORDS;
	localparam int NUM_BANKS       = 2;
	localparam int RAM_WORDS       = NUM_BANKS * BANK_WORDS;
	localparam int RAM_AW          = $clog2(RAM_WORDS);
	localparam int CMP_W           = 11;

	typedef logic [PLEN_W-1:0] plen_t;
	typedef logic [RAM_AW-1:0] ram_addr_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_BAD_ID  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_CART = 2'd0,
		KIND_GEOD = 2'd1,
		KIND_COV  = 2'd2,
		KIND_DOP  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_HUNT1   = 2'd0,
		PH_HUNT2   = 2'd1,
		PH_HEADER  = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		CFG_SYNC_FIRST  = 3'd0,
		CFG_SYNC_SECOND = 3'd1,
		CFG_ID_CART     = 3'd2,
		CFG_ID_GEOD     = 3'd3,
		CFG_ID_COV      = 3'd4,
		CFG_ID_DOP      = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [12:0] id_cart;
		logic [12:0] id_geod;
		logic [12:0] id_cov;
		logic [12:0] id_dop;
	} cfg_t;

	// One decode job handed from the front to the back
	typedef struct packed {
		status_t    status;
		kind_t      kind;
		logic [3:0] count;
		plen_t      plen;
		logic       bank;
		logic       has_bank;
		logic       complete;
	} job_t;

	typedef struct packed {
		logic       en;
		ram_addr_t  addr;
		logic [2:0] lane;
		logic [7:0] data;
	} ram_wr_t;

	typedef struct packed {
		status_t     status;
		kind_t       kind;
		logic [3:0]  slot;
		logic [63:0] value;
		logic        last;
		logic        complete;
	} result_t;

	typedef struct packed {
		logic [6:0] off;
		logic [3:0] nbytes;
	} field_pos_t;

	// Number of fields of each block kind
	function automatic logic [3:0] field_count(kind_t kind);
		logic [3:0] n;
		unique case (kind)
			KIND_CART: n = 4'd12;
			KIND_GEOD: n = 4'd7;
			KIND_COV:  n = 4'd10;
			KIND_DOP:  n = 4'd7;
			default:   n = 4'd7;
		endcase
		return n;
	endfunction

	// Payload offset and size of each field; no field straddles an 8-byte word
	function automatic field_pos_t field_pos(kind_t kind, logic [3:0] slot);
		field_pos_t p;
		p = '{off: 7'd0, nbytes: 4'd4};
		if (kind == KIND_DOP) begin
			unique case (slot)
				4'd0:    p = '{off: 7'd0,  nbytes: 4'd4};
				4'd1:    p = '{off: 7'd4,  nbytes: 4'd2};
				4'd2:    p = '{off: 7'd6,  nbytes: 4'd1};
				4'd3:    p = '{off: 7'd8,  nbytes: 4'd2};
				4'd4:    p = '{off: 7'd10, nbytes: 4'd2};
				4'd5:    p = '{off: 7'd12, nbytes: 4'd2};
				4'd6:    p = '{off: 7'd14, nbytes: 4'd2};
				default: p = '{off: 7'd0,  nbytes: 4'd4};
			endcase
		end else if (kind == KIND_COV && slot >= 4'd4) begin
			unique case (slot)
				4'd4:    p = '{off: 7'd8,  nbytes: 4'd4};
				4'd5:    p = '{off: 7'd12, nbytes: 4'd4};
				4'd6:    p = '{off: 7'd16, nbytes: 4'd4};
				4'd7:    p = '{off: 7'd24, nbytes: 4'd4};
				4'd8:    p = '{off: 7'd28, nbytes: 4'd4};
				4'd9:    p = '{off: 7'd36, nbytes: 4'd4};
				default: p = '{off: 7'd0,  nbytes: 4'd4};
			endcase
		end else begin
			unique case (slot)
				4'd0:    p = '{off: 7'd0,  nbytes: 4'd4};
				4'd1:    p = '{off: 7'd4,  nbytes: 4'd2};
				4'd2:    p = '{off: 7'd6,  nbytes: 4'd1};
				4'd3:    p = '{off: 7'd7,  nbytes: 4'd1};
				4'd4:    p = '{off: 7'd8,  nbytes: 4'd8};
				4'd5:    p = '{off: 7'd16, nbytes: 4'd8};
				4'd6:    p = '{off: 7'd24, nbytes: 4'd8};
				4'd7:    p = '{off: 7'd32, nbytes: 4'd4};
				4'd8:    p = '{off: 7'd36, nbytes: 4'd4};
				4'd9:    p = '{off: 7'd40, nbytes: 4'd4};
				4'd10:   p = '{off: 7'd44, nbytes: 4'd4};
				4'd11:   p = '{off: 7'd66, nbytes: 4'd1};
				default: p = '{off: 7'd0,  nbytes: 4'd4};
			endcase
		end
		return p;
	endfunction

endpackage

### rtl/sbf_block_deframer.sv
// Binary block deframer: received bytes in, one result per decoded field out.
//
// Input channel: a byte is taken on a clock edge with push high and full low.
// Result channel: the oldest result is on the result ports while empty is low
// and is taken on an edge with pop high. Configuration: a write is taken on an
// edge with cfg_valid and cfg_ready high; cfg_ready is always high. Writes
// must be made only while the block is idle; the block does not enforce this.
// Throughput: one byte per cycle on input and one result per cycle on output.
// The front end stalls (full) only when the job queue is full or both payload
// banks are still being decoded. The back end reads one 64-bit payload word
// per field. With the job queue otherwise empty, the first result of a block
// follows the byte that ends it through the job queue entry, the registered
// payload read, then extraction into the result queue. When the receiver
// stalls, the four-entry result queue fills and the back end holds; bytes
// keep flowing until the job queue is full or both banks are held and a
// payload byte arrives.
// Reset clears all control state and reloads the configuration defaults; the
// payload store is not cleared and needs no pass.
module sbf_block_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [7:0]  rx_byte,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [1:0]  block_kind,
	output logic [3:0]  field_slot,
	output logic [63:0] field_value,
	output logic        last,
	output logic        set_complete,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sbf_pkg::*;

	cfg_t      cfg_q;
	logic      jq_push;
	job_t      jq_wdata;
	logic      jq_full;
	logic      jq_pop;
	job_t      jq_head;
	logic      jq_empty;
	logic      rel;
	ram_wr_t   ram_wr;
	logic      rd_en;
	ram_addr_t rd_addr;
	logic [63:0] rd_data;
	result_t   res;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= 8'd36;
			cfg_q.sync_second <= 8'd64;
			cfg_q.id_cart     <= 13'd4006;
			cfg_q.id_geod     <= 13'd4007;
			cfg_q.id_cov      <= 13'd5905;
			cfg_q.id_dop      <= 13'd4001;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data[7:0];
				CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data[7:0];
				CFG_ID_CART:     cfg_q.id_cart     <= cfg_data[12:0];
				CFG_ID_GEOD:     cfg_q.id_geod     <= cfg_data[12:0];
				CFG_ID_COV:      cfg_q.id_cov      <= cfg_data[12:0];
				CFG_ID_DOP:      cfg_q.id_dop      <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	sbf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.rx_byte      (rx_byte),
		.full         (full),
		.cfg          (cfg_q),
		.jq_full      (jq_full),
		.jq_push      (jq_push),
		.jq_data      (jq_wdata),
		.release_bank (rel),
		.ram_wr       (ram_wr)
	);

	sbf_job_fifo u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (jq_push),
		.wr_data (jq_wdata),
		.full    (jq_full),
		.rd_en   (jq_pop),
		.rd_data (jq_head),
		.empty   (jq_empty)
	);

	sbf_pay_ram u_pay_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sbf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.jq_empty     (jq_empty),
		.jq_head      (jq_head),
		.jq_pop       (jq_pop),
		.release_bank (rel),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.empty        (empty),
		.pop          (pop),
		.res          (res)
	);

	assign status       = res.status;
	assign block_kind   = res.kind;
	assign field_slot   = res.slot;
	assign field_value  = res.value;
	assign last         = res.last;
	assign set_complete = res.complete;

`ifndef ASSERT_OFF
	// A job is never pushed into a full queue
	a_jq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		jq_push |-> !jq_full)
		else $error("job pushed into full queue");

	// The back end only retires a job that exists
	a_jq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		jq_pop |-> !jq_empty)
		else $error("job popped from empty queue");

	// A bank is released only when its job retires
	a_release_with_job: assert property (@(posedge clk) disable iff (!arst_n)
		rel |-> (jq_pop && jq_head.has_bank))
		else $error("payload bank released without its job");

	// Error results stand alone
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (last && !set_complete))
		else $error("error result not marked last");
`endif

endmodule

### rtl/sbf_pay_ram.sv
// Two-bank payload store, 64-bit words with byte-lane writes.
// Depends on sbf_pkg for the store geometry and the write bundle.
module sbf_pay_ram (
	input  logic              clk,
	input  sbf_pkg::ram_wr_t  wr,
	input  logic              rd_en,
	input  sbf_pkg::ram_addr_t rd_addr,
	output logic [63:0]       rd_data
);
	import sbf_pkg::*;

	logic [7:0] mem [RAM_WORDS][8];

	// Write one byte lane
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr][wr.lane] <= wr.data;
		end
	end

	// Read one whole word, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			for (int i = 0; i < 8; i++) begin
				rd_data[i*8 +: 8] <= mem[rd_addr][i];
			end
		end
	end

endmodule

### rtl/sbf_front.sv
// Front end: sync hunt, header capture, payload write and block classification.
// Depends on sbf_pkg; pushes one decode job per finished or rejected block.
module sbf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       rx_byte,
	output logic             full,
	input  sbf_pkg::cfg_t    cfg,
	input  logic             jq_full,
	output logic             jq_push,
	output sbf_pkg::job_t    jq_data,
	input  logic             release_bank,
	output sbf_pkg::ram_wr_t ram_wr
);
	import sbf_pkg::*;

	localparam logic [2:0] HDR_ID_LO  = 3'd2;
	localparam logic [2:0] HDR_ID_HI  = 3'd3;
	localparam logic [2:0] HDR_LEN_LO = 3'd4;
	localparam logic [2:0] HDR_LAST   = 3'd5;
	localparam logic [1:0] BANKS_ALL  = 2'(NUM_BANKS);

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_cnt_q;
	logic [12:0] id_q;
	logic [7:0]  len_lo_q;
	plen_t       plen_q;
	plen_t       pcnt_q;
	logic [7:0]  pvt_q;
	logic [3:0]  seen_q;
	logic        wr_bank_q;
	logic [1:0]  busy_q;

	logic        acc;
	logic [15:0] length;
	logic        len_bad;
	logic [7:0]  pvt_now;
	logic        last_byte;
	logic [3:0]  hit;
	kind_t       kind;
	logic [3:0]  seen_next;
	logic        claim;
	ram_addr_t   bank_base;

	assign full = jq_full || (phase_q == PH_PAYLOAD && busy_q == BANKS_ALL);
	assign acc  = push && !full;

	// Header length and payload bookkeeping
	assign length    = {rx_byte, len_lo_q};
	assign len_bad   = (length[1:0] != 2'd0) || (length < 16'd9) ||
	                   (length > 16'(MAX_BLOCK_BYTES));
	assign pvt_now   = (pcnt_q == plen_t'(7)) ? rx_byte : pvt_q;
	assign last_byte = (plen_t'(pcnt_q + 1'b1) == plen_q);

	// Classify the block id, lowest kind wins
	assign hit = {id_q == cfg.id_dop, id_q == cfg.id_cov,
	              id_q == cfg.id_geod, id_q == cfg.id_cart};
	always_comb begin
		if (hit[0]) begin
			kind = KIND_CART;
		end else if (hit[1]) begin
			kind = KIND_GEOD;
		end else if (hit[2]) begin
			kind = KIND_COV;
		end else begin
			kind = KIND_DOP;
		end
	end
	assign seen_next = seen_q | (4'd1 << kind);

	// Build the decode job and the next phase
	always_comb begin
		phase_d = phase_q;
		jq_push = 1'b0;
		claim   = 1'b0;
		jq_data = '{status: ST_OK, kind: KIND_CART, count: 4'd1, plen: plen_q,
		            bank: wr_bank_q, has_bank: 1'b0, complete: 1'b0};
		if (acc) begin
			unique case (phase_q)
				PH_HUNT1: begin
					if (rx_byte == cfg.sync_first) begin
						phase_d = PH_HUNT2;
					end
				end
				PH_HUNT2: begin
					if (rx_byte == cfg.sync_second) begin
						phase_d = PH_HEADER;
					end else if (rx_byte != cfg.sync_first) begin
						phase_d = PH_HUNT1;
					end
				end
				PH_HEADER: begin
					if (hdr_cnt_q == HDR_LAST) begin
						if (len_bad) begin
							phase_d        = PH_HUNT1;
							jq_push        = 1'b1;
							jq_data.status = ST_BAD_LEN;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					if (last_byte) begin
						phase_d = PH_HUNT1;
						jq_push = 1'b1;
						if (hit == 4'd0) begin
							jq_data.status = ST_BAD_ID;
						end else begin
							claim            = 1'b1;
							jq_data.kind     = kind;
							jq_data.has_bank = 1'b1;
							jq_data.complete = (seen_next == 4'hF);
							jq_data.count    = (kind != KIND_DOP && pvt_now != 8'd0) ?
							                   4'd4 : field_count(kind);
						end
					end
				end
				default: phase_d = PH_HUNT1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Header, payload counters and block tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			id_q      <= '0;
			len_lo_q  <= '0;
			plen_q    <= '0;
			pcnt_q    <= '0;
			pvt_q     <= '0;
			seen_q    <= '0;
			wr_bank_q <= 1'b0;
		end else if (acc) begin
			if (phase_q == PH_HUNT2 && rx_byte == cfg.sync_second) begin
				hdr_cnt_q <= '0;
			end
			if (phase_q == PH_HEADER) begin
				hdr_cnt_q <= (hdr_cnt_q == HDR_LAST) ? 3'd0 : hdr_cnt_q + 3'd1;
				if (hdr_cnt_q == HDR_ID_LO) begin
					id_q[7:0] <= rx_byte;
				end
				if (hdr_cnt_q == HDR_ID_HI) begin
					id_q[12:8] <= rx_byte[4:0];
				end
				if (hdr_cnt_q == HDR_LEN_LO) begin
					len_lo_q <= rx_byte;
				end
				if (hdr_cnt_q == HDR_LAST) begin
					plen_q <= plen_t'(length - 16'(HDR_BYTES));
					pcnt_q <= '0;
					pvt_q  <= '0;
					if (len_bad) begin
						seen_q <= '0;
					end
				end
			end
			if (phase_q == PH_PAYLOAD) begin
				pcnt_q <= plen_t'(pcnt_q + 1'b1);
				pvt_q  <= pvt_now;
				if (last_byte) begin
					if (hit == 4'd0 || seen_next == 4'hF) begin
						seen_q <= '0;
					end else begin
						seen_q <= seen_next;
					end
					if (hit != 4'd0) begin
						wr_bank_q <= ~wr_bank_q;
					end
				end
			end
		end
	end

	// Count banks held by the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			busy_q <= busy_q + {1'b0, claim} - {1'b0, release_bank};
		end
	end

	// Write payload bytes into the current bank
	assign bank_base   = wr_bank_q ? ram_addr_t'(BANK_WORDS) : '0;
	assign ram_wr.en   = acc && phase_q == PH_PAYLOAD;
	assign ram_wr.addr = bank_base + ram_addr_t'(pcnt_q >> 3);
	assign ram_wr.lane = pcnt_q[2:0];
	assign ram_wr.data = rx_byte;

endmodule

### rtl/sbf_job_fifo.sv
// Two-entry queue of decode jobs between the front and back ends.
// Depends on sbf_pkg for the job type.
module sbf_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sbf_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output sbf_pkg::job_t rd_data,
	output logic          empty
);
	import sbf_pkg::*;

	job_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = slot_q[rptr_q];

	// Hold job payload
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

### rtl/sbf_back.sv
// Back end: walks a job's field list, reads one payload word per field,
// extracts the field and queues the result. Depends on sbf_pkg.
module sbf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               jq_empty,
	input  sbf_pkg::job_t      jq_head,
	output logic               jq_pop,
	output logic               release_bank,
	output logic               rd_en,
	output sbf_pkg::ram_addr_t rd_addr,
	input  logic [63:0]        rd_data,
	output logic               empty,
	input  logic               pop,
	output sbf_pkg::result_t   res
);
	import sbf_pkg::*;

	localparam int         ODEPTH = 4;
	localparam logic [2:0] OFULL  = 3'(ODEPTH);

	logic [3:0]  slot_q;
	logic        issue;
	logic        last_slot;
	field_pos_t  pos;
	ram_addr_t   bank_base;

	logic        valid_s1;
	status_t     status_s1;
	kind_t       kind_s1;
	logic [3:0]  slot_s1;
	field_pos_t  pos_s1;
	plen_t       plen_s1;
	logic        last_s1;
	logic        complete_s1;

	logic [63:0] shifted;
	logic [63:0] value;
	result_t     res_new;

	result_t     oq_q [ODEPTH];
	logic [1:0]  owptr_q;
	logic [1:0]  orptr_q;
	logic [2:0]  ocnt_q;
	logic        pop_acc;

	// Issue one field read per cycle while the result queue has room
	assign issue     = !jq_empty && ((ocnt_q + {2'b0, valid_s1}) < OFULL);
	assign last_slot = (slot_q == jq_head.count - 4'd1);
	assign jq_pop    = issue && last_slot;
	assign release_bank = jq_pop && jq_head.has_bank;
	assign pos       = field_pos(jq_head.kind, slot_q);
	assign bank_base = jq_head.bank ? ram_addr_t'(BANK_WORDS) : '0;
	assign rd_en     = issue;
	assign rd_addr   = bank_base + ram_addr_t'(pos.off[6:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (issue) begin
			slot_q <= last_slot ? 4'd0 : slot_q + 4'd1;
		end
	end

	// Stage 1: field descriptor waits for the registered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1   <= jq_head.status;
			kind_s1     <= jq_head.kind;
			slot_s1     <= slot_q;
			pos_s1      <= pos;
			plen_s1     <= jq_head.plen;
			last_s1     <= last_slot;
			complete_s1 <= jq_head.complete;
		end
	end

	// Extract the field, zero bytes past its size or past the received payload
	assign shifted = rd_data >> {pos_s1.off[2:0], 3'b000};
	always_comb begin
		value = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < pos_s1.nbytes &&
			    (CMP_W'(pos_s1.off) + CMP_W'(i)) < CMP_W'(plen_s1)) begin
				value[i*8 +: 8] = shifted[i*8 +: 8];
			end
		end
	end

	always_comb begin
		res_new = '{status: status_s1, kind: kind_s1, slot: slot_s1, value: value,
		            last: last_s1, complete: complete_s1};
		if (status_s1 != ST_OK) begin
			res_new.kind  = KIND_CART;
			res_new.slot  = '0;
			res_new.value = '0;
		end
	end

	// Result queue
	assign empty   = (ocnt_q == 3'd0);
	assign pop_acc = pop && !empty;
	assign res     = oq_q[orptr_q];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[owptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (valid_s1) begin
				owptr_q <= owptr_q + 2'd1;
			end
			if (pop_acc) begin
				orptr_q <= orptr_q + 2'd1;
			end
			ocnt_q <= ocnt_q + {2'b0, valid_s1} - {2'b0, pop_acc};
		end
	end

endmodule
